FILE: design/kdb_pkg.sv
// package with shared constants and types for the key debounce block
`timescale 1ns / 1ps

package kdb_pkg;

    // default sizes
    localparam int NUM_KEYS_DEF   = 16;
    localparam int TICK_WIDTH_DEF = 32;

    // fixed field widths
    localparam int KEY_IDX_W  = 4;
    localparam int MS_W       = 16;
    localparam int PERIOD_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [MS_W-1:0]     DEBOUNCE_RST = 16'd100;
    localparam logic [MS_W-1:0]     HOLD_RST     = 16'd2000;
    localparam logic [PERIOD_W-1:0] PERIOD_RST   = 8'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 2'd2;

    // event kinds
    localparam logic KIND_HOLD  = 1'b0;
    localparam logic KIND_PRESS = 1'b1;

    // scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEBOUNCE,
        ST_EVAL,
        ST_DRAIN
    } state_t;

endpackage

FILE: design/kdb_lane.sv
// one key lane: press timestamp register and hold time comparison
`timescale 1ns / 1ps

module kdb_lane #(
    parameter int TICK_WIDTH = kdb_pkg::TICK_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         load,
    input  logic [TICK_WIDTH-1:0]        now_tick,
    input  logic [kdb_pkg::PERIOD_W-1:0] tick_period_ms,
    input  logic [kdb_pkg::MS_W-1:0]     hold_ms,
    input  logic                         key_held,
    output logic                         hold_hit
);

    localparam int ELAPSED_W = TICK_WIDTH + kdb_pkg::PERIOD_W;

    logic [TICK_WIDTH-1:0] press_tick_reg;
    logic [TICK_WIDTH-1:0] ticks;
    logic [ELAPSED_W-1:0]  elapsed;

    // press time of the key, captured on the stable scan that first shows it down
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            press_tick_reg <= now_tick;
        end
    end

    // wrapped tick difference scaled to ms, then the hold threshold
    assign ticks    = now_tick - press_tick_reg;
    assign elapsed  = ELAPSED_W'(ticks) * ELAPSED_W'(tick_period_ms);
    assign hold_hit = key_held && (elapsed >= ELAPSED_W'(hold_ms));

endmodule

FILE: design/kdb_merge.sv
// merging stage: serializes the lane results into events, holds first then presses
`timescale 1ns / 1ps

module kdb_merge #(
    parameter int NUM_KEYS = kdb_pkg::NUM_KEYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [NUM_KEYS-1:0]           hold_vec,
    input  logic [NUM_KEYS-1:0]           press_vec,
    output logic                          busy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kdb_pkg::KEY_IDX_W-1:0] key_index,
    output logic                          event_kind,
    output logic                          last_event
);

    localparam int PEND_W     = 2 * NUM_KEYS;
    localparam int PEND_IDX_W = $clog2(PEND_W);

    logic [PEND_W-1:0]              pending_reg;
    logic [PEND_W-1:0]              pending_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [kdb_pkg::KEY_IDX_W-1:0]  key_reg;
    logic [kdb_pkg::KEY_IDX_W-1:0]  key_next;
    logic                           kind_reg;
    logic                           kind_next;
    logic                           last_reg;
    logic                           last_next;

    logic                  found;
    logic [PEND_IDX_W-1:0] sel_idx;
    logic [PEND_W-1:0]     sel_onehot;
    logic [PEND_W-1:0]     rest;
    logic                  sel_press;
    logic                  advance;

    // lowest pending bit: holds sit below presses, so holds leave first
    always_comb
    begin
        found      = 1'b0;
        sel_idx    = '0;
        sel_onehot = '0;
        for (int j = 0; j < PEND_W; j++)
        begin
            if (!found && pending_reg[j])
            begin
                found         = 1'b1;
                sel_idx       = PEND_IDX_W'(j);
                sel_onehot[j] = 1'b1;
            end
        end
    end

    assign rest      = pending_reg & ~sel_onehot;
    assign sel_press = (sel_idx >= PEND_IDX_W'(NUM_KEYS));
    assign advance   = found && (!out_valid_reg || !out_stall);

    // next values of the queue and the output register
    always_comb
    begin
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        key_next       = key_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            pending_next   = rest;
            out_valid_next = 1'b1;
            kind_next      = sel_press ? kdb_pkg::KIND_PRESS : kdb_pkg::KIND_HOLD;
            key_next       = sel_press
                           ? kdb_pkg::KEY_IDX_W'(sel_idx - PEND_IDX_W'(NUM_KEYS))
                           : kdb_pkg::KEY_IDX_W'(sel_idx);
            last_next      = (rest == '0);
        end
        if (load)
        begin
            pending_next = {press_vec, hold_vec};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // event payload
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign busy       = |pending_reg;
    assign out_valid  = out_valid_reg;
    assign key_index  = key_reg;
    assign event_kind = kind_reg;
    assign last_event = last_reg;

endmodule

FILE: design/key_debounce_press_hold_events_top.sv
// Key debounce with press and hold events. One transaction on the input carries a key
// scan bitmap and a tick timestamp. A scan is stable once the bitmap has stayed unchanged
// for strictly longer than debounce_ms; on a stable scan each key lane records new press
// times and checks its hold time in parallel, and the merge stage sends one event per
// cycle while the output does not stall: HOLD events by ascending key, then PRESS events for
// short presses released, the final one flagged by last_event. A scan is captured in idle,
// judged in the debounce state and evaluated in the eval state, which loads the merge stage;
// its events then pass through the single output register, and the sequencer goes back to
// idle once the last event has entered that register. Configuration writes are always
// ready and take effect the next cycle.
`timescale 1ns / 1ps

module key_debounce_press_hold_events_top #(
    parameter int NUM_KEYS   = kdb_pkg::NUM_KEYS_DEF,
    parameter int TICK_WIDTH = kdb_pkg::TICK_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // scan input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [NUM_KEYS-1:0]             keys_down,
    input  logic [TICK_WIDTH-1:0]           now_tick,
    // event output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [kdb_pkg::KEY_IDX_W-1:0]   key_index,
    output logic                            event_kind,
    output logic                            last_event,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kdb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kdb_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int ELAPSED_W = TICK_WIDTH + kdb_pkg::PERIOD_W;

    kdb_pkg::state_t state_reg;
    kdb_pkg::state_t state_next;

    logic [kdb_pkg::MS_W-1:0]     debounce_ms_reg;
    logic [kdb_pkg::MS_W-1:0]     hold_ms_reg;
    logic [kdb_pkg::PERIOD_W-1:0] period_reg;

    logic [NUM_KEYS-1:0]   keys_reg;
    logic [TICK_WIDTH-1:0] now_reg;
    logic [NUM_KEYS-1:0]   cand_keys_reg;
    logic [NUM_KEYS-1:0]   cand_keys_next;
    logic [TICK_WIDTH-1:0] cand_since_reg;
    logic [TICK_WIDTH-1:0] cand_since_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic [NUM_KEYS-1:0]   stable_reg;
    logic [NUM_KEYS-1:0]   stable_next;
    logic [NUM_KEYS-1:0]   released_reg;
    logic [NUM_KEYS-1:0]   released_next;
    logic [NUM_KEYS-1:0]   hold_sent_reg;
    logic [NUM_KEYS-1:0]   hold_sent_next;

    logic                  in_accept;
    logic                  new_candidate;
    logic [TICK_WIDTH-1:0] deb_ticks;
    logic [ELAPSED_W-1:0]  deb_elapsed;
    logic                  deb_done;
    logic [NUM_KEYS-1:0]   lane_load;
    logic [NUM_KEYS-1:0]   hold_vec;
    logic [NUM_KEYS-1:0]   press_vec;
    logic                  merge_load;
    logic                  merge_busy;

    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= kdb_pkg::DEBOUNCE_RST;
            hold_ms_reg     <= kdb_pkg::HOLD_RST;
            period_reg      <= kdb_pkg::PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kdb_pkg::REG_DEBOUNCE: debounce_ms_reg <= cfg_data;
                kdb_pkg::REG_HOLD:     hold_ms_reg     <= cfg_data;
                kdb_pkg::REG_PERIOD:   period_reg      <= cfg_data[kdb_pkg::PERIOD_W-1:0];
                default:               ;
            endcase
        end
    end

    // captured scan
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            keys_reg <= keys_down;
            now_reg  <= now_tick;
        end
    end

    // debounce check on the candidate bitmap
    assign new_candidate = !seen_reg || (cand_keys_reg != keys_reg);
    assign deb_ticks     = now_reg - cand_since_reg;
    assign deb_elapsed   = ELAPSED_W'(deb_ticks) * ELAPSED_W'(period_reg);
    assign deb_done      = deb_elapsed > ELAPSED_W'(debounce_ms_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kdb_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = kdb_pkg::ST_DEBOUNCE;
                end
            end
            kdb_pkg::ST_DEBOUNCE:
            begin
                if (new_candidate || !deb_done)
                begin
                    state_next = kdb_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = kdb_pkg::ST_EVAL;
                end
            end
            kdb_pkg::ST_EVAL:
            begin
                if ((hold_vec | press_vec) == '0)
                begin
                    state_next = kdb_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = kdb_pkg::ST_DRAIN;
                end
            end
            kdb_pkg::ST_DRAIN:
            begin
                if (!merge_busy)
                begin
                    state_next = kdb_pkg::ST_IDLE;
                end
            end
            default: state_next = kdb_pkg::ST_IDLE;
        endcase
    end

    // outputs and key state updates
    always_comb
    begin
        in_stall        = 1'b1;
        lane_load       = '0;
        merge_load      = 1'b0;
        cand_keys_next  = cand_keys_reg;
        cand_since_next = cand_since_reg;
        seen_next       = seen_reg;
        stable_next     = stable_reg;
        released_next   = released_reg;
        hold_sent_next  = hold_sent_reg;
        case (state_reg)
            kdb_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            kdb_pkg::ST_DEBOUNCE:
            begin
                if (new_candidate)
                begin
                    seen_next       = 1'b1;
                    cand_keys_next  = keys_reg;
                    cand_since_next = now_reg;
                end
                else if (deb_done)
                begin
                    lane_load     = keys_reg & ~stable_reg;
                    released_next = stable_reg & ~keys_reg;
                    stable_next   = keys_reg;
                end
            end
            kdb_pkg::ST_EVAL:
            begin
                merge_load     = 1'b1;
                hold_sent_next = (hold_sent_reg | hold_vec) & ~released_reg;
            end
            kdb_pkg::ST_DRAIN:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // presses released without a hold event
    assign press_vec = released_reg & ~hold_sent_reg;

    // sequencer and key state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kdb_pkg::ST_IDLE;
            cand_keys_reg  <= '0;
            cand_since_reg <= '0;
            seen_reg       <= 1'b0;
            stable_reg     <= '0;
            released_reg   <= '0;
            hold_sent_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cand_keys_reg  <= cand_keys_next;
            cand_since_reg <= cand_since_next;
            seen_reg       <= seen_next;
            stable_reg     <= stable_next;
            released_reg   <= released_next;
            hold_sent_reg  <= hold_sent_next;
        end
    end

    // one lane per key
    for (genvar i = 0; i < NUM_KEYS; i++)
    begin : g_lane
        kdb_lane #(
            .TICK_WIDTH (TICK_WIDTH)
        ) u_lane (
            .clk            (clk),
            .load           (lane_load[i]),
            .now_tick       (now_reg),
            .tick_period_ms (period_reg),
            .hold_ms        (hold_ms_reg),
            .key_held       (keys_reg[i]),
            .hold_hit       (hold_vec[i])
        );
    end

    // event serializer
    kdb_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (merge_load),
        .hold_vec   (hold_vec),
        .press_vec  (press_vec),
        .busy       (merge_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_index  (key_index),
        .event_kind (event_kind),
        .last_event (last_event)
    );

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the key debounce block with press and hold events
`timescale 1ns / 1ps

module testbench;

    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 12;

    // index past the last register, writes to it must be dropped
    localparam logic [kdb_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [kdb_pkg::KEY_IDX_W-1:0] key;
        logic                          kind;
        logic                          last;
    } key_event_t;

    // one directed scan; typed rows carry their events as hold and press masks
    typedef struct packed {
        logic [15:0] keys;
        logic [31:0] tick;
        logic        typed;
        logic [15:0] hold_mask;
        logic [15:0] press_mask;
    } scan_row_t;

    typedef struct packed {
        logic [15:0] debounce;
        logic [15:0] hold;
        logic [15:0] period;
        logic        spare_write;
        int          scans;
    } cfg_phase_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [15:0]                    keys_down;
    logic [31:0]                    now_tick;
    logic                           out_valid;
    logic                           out_stall;
    logic [kdb_pkg::KEY_IDX_W-1:0]  key_index;
    logic                           event_kind;
    logic                           last_event;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [kdb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [kdb_pkg::CFG_DATA_W-1:0] cfg_data;

    // predicted state of the block
    logic [15:0]                  cand_keys;
    logic [31:0]                  cand_tick;
    logic                         scan_seen;
    logic [15:0]                  settled_keys;
    logic [31:0]                  down_tick [16];
    logic [15:0]                  hold_flagged;
    logic [kdb_pkg::MS_W-1:0]     cfg_debounce;
    logic [kdb_pkg::MS_W-1:0]     cfg_hold;
    logic [kdb_pkg::PERIOD_W-1:0] cfg_period;

    key_event_t pending_events [$];
    key_event_t scan_events [$];
    int         mismatches;
    int         quiet_cycles;
    int         send_gap_pct;
    int         stall_pct;

    // directed scans under the reset register values
    scan_row_t scan_table [0:25] = '{
        // first scan after reset only loads the candidate
        '{16'hFFFF, 32'd0,        1'b1, 16'h0000, 16'h0000},
        '{16'hFFFF, 32'd50,       1'b1, 16'h0000, 16'h0000},
        '{16'hFFFF, 32'd101,      1'b1, 16'h0000, 16'h0000},
        '{16'hFFFF, 32'd2101,     1'b1, 16'hFFFF, 16'h0000},
        // release after hold gives no press event
        '{16'h0000, 32'd2200,     1'b1, 16'h0000, 16'h0000},
        '{16'h0000, 32'd2301,     1'b1, 16'h0000, 16'h0000},
        '{16'h0001, 32'd2400,     1'b1, 16'h0000, 16'h0000},
        '{16'h0001, 32'd2501,     1'b1, 16'h0000, 16'h0000},
        '{16'h8000, 32'd2600,     1'b1, 16'h0000, 16'h0000},
        '{16'h8000, 32'd2701,     1'b1, 16'h0000, 16'h0001},
        // one ms short of hold, then exactly hold, then repeated hold
        '{16'h8000, 32'd4700,     1'b1, 16'h0000, 16'h0000},
        '{16'h8000, 32'd4701,     1'b1, 16'h8000, 16'h0000},
        '{16'h8000, 32'd4800,     1'b1, 16'h8000, 16'h0000},
        // exactly debounce does not settle, one more ms does
        '{16'h0000, 32'd4900,     1'b1, 16'h0000, 16'h0000},
        '{16'h0000, 32'd5000,     1'b1, 16'h0000, 16'h0000},
        '{16'h0000, 32'd5001,     1'b1, 16'h0000, 16'h0000},
        // debounce across tick wrap
        '{16'h00F0, 32'hFFFFFFC0, 1'b1, 16'h0000, 16'h0000},
        '{16'h00F0, 32'h00000030, 1'b1, 16'h0000, 16'h0000},
        '{16'h0050, 32'h00000100, 1'b1, 16'h0000, 16'h0000},
        '{16'h0050, 32'h00000200, 1'b1, 16'h0000, 16'h00A0},
        '{16'hAAAA, 32'h7FFFFFFF, 1'b1, 16'h0000, 16'h0000},
        '{16'hAAAA, 32'hFFFFFFFF, 1'b1, 16'h0000, 16'h0050},
        // hold measured across tick wrap, then holds and a press together
        '{16'hAAAB, 32'h00000700, 1'b1, 16'h0000, 16'h0000},
        '{16'hAAAB, 32'h000007CF, 1'b0, 16'h0000, 16'h0000},
        '{16'hAAAA, 32'h00000800, 1'b1, 16'h0000, 16'h0000},
        '{16'hAAAA, 32'h00000900, 1'b0, 16'h0000, 16'h0000}
    };

    // register settings of the random part
    cfg_phase_t phase_table [0:4] = '{
        '{16'd0,        16'd0,    16'd1,              1'b0, 60},
        '{16'hFFFF,     16'hFFFF, 16'd255,            1'b0, 60},
        // period truncates to zero, so no scan ever settles
        '{16'd40,       16'd300,  16'h0100,           1'b0, 20},
        '{16'd30,       16'd200,  16'd3,              1'b0, 90},
        '{kdb_pkg::DEBOUNCE_RST, kdb_pkg::HOLD_RST, {8'd0, kdb_pkg::PERIOD_RST}, 1'b1, 90}
    };

    key_debounce_press_hold_events_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .keys_down  (keys_down),
        .now_tick   (now_tick),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_index  (key_index),
        .event_kind (event_kind),
        .last_event (last_event),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial clk = 1'b0;

    always #5 clk = ~clk;

    // elapsed ms between two ticks, wrapped tick difference at full precision
    function automatic logic [39:0] span_ms(input logic [31:0] later, input logic [31:0] earlier);
        logic [31:0] ticks;
        ticks = later - earlier;
        return {8'd0, ticks} * {32'd0, cfg_period};
    endfunction

    // events of one scan into scan_events, state updated
    task automatic judge_scan(input logic [15:0] k, input logic [31:0] t);
        logic [15:0] released;
        logic [15:0] pressed;
        int i;
        scan_events.delete();
        if (!scan_seen || cand_keys != k)
        begin
            scan_seen = 1'b1;
            cand_keys = k;
            cand_tick = t;
        end
        else if (span_ms(t, cand_tick) > {24'd0, cfg_debounce})
        begin
            released     = settled_keys & ~k;
            pressed      = k & ~settled_keys;
            settled_keys = k;
            for (i = 0; i < 16; i++)
                if (pressed[i])
                    down_tick[i] = t;
            for (i = 0; i < 16; i++)
            begin
                if (k[i] && span_ms(t, down_tick[i]) >= {24'd0, cfg_hold})
                begin
                    scan_events.push_back('{key: 4'(i), kind: kdb_pkg::KIND_HOLD, last: 1'b0});
                    hold_flagged[i] = 1'b1;
                end
            end
            for (i = 0; i < 16; i++)
            begin
                if (released[i])
                begin
                    if (hold_flagged[i])
                        hold_flagged[i] = 1'b0;
                    else
                        scan_events.push_back('{key: 4'(i), kind: kdb_pkg::KIND_PRESS,
                                                last: 1'b0});
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // one scan transaction; entered and left just after a falling edge
    task automatic send_scan(input logic [15:0] k, input logic [31:0] t, input logic typed,
                             input logic [15:0] hold_mask, input logic [15:0] press_mask);
        int i;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        keys_down <= k;
        now_tick  <= t;
        do
            @(posedge clk);
        while (in_stall);
        judge_scan(k, t);
        if (typed)
        begin
            scan_events.delete();
            for (i = 0; i < 16; i++)
                if (hold_mask[i])
                    scan_events.push_back('{key: 4'(i), kind: kdb_pkg::KIND_HOLD, last: 1'b0});
            for (i = 0; i < 16; i++)
                if (press_mask[i])
                    scan_events.push_back('{key: 4'(i), kind: kdb_pkg::KIND_PRESS, last: 1'b0});
        end
        if (scan_events.size() != 0)
            scan_events[scan_events.size() - 1].last = 1'b1;
        foreach (scan_events[e])
            pending_events.push_back(scan_events[e]);
        @(negedge clk);
    endtask

    // register write; cfg_valid is left high for a following write
    task automatic write_reg(input logic [kdb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [kdb_pkg::CFG_DATA_W-1:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            kdb_pkg::REG_DEBOUNCE: cfg_debounce = d;
            kdb_pkg::REG_HOLD:     cfg_hold = d;
            kdb_pkg::REG_PERIOD:   cfg_period = d[kdb_pkg::PERIOD_W-1:0];
            default:               ;
        endcase
        @(negedge clk);
    endtask

    // wait until every event is out and a scan with no events has finished
    task automatic settle;
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // receiver stall
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // event checker and activity counter
    always @(posedge clk)
    begin : check_events
        key_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_events.size() == 0)
                report_mismatch($sformatf("event for key %0d kind %0d with none pending",
                                          key_index, event_kind));
            else
            begin
                want = pending_events.pop_front();
                if (key_index !== want.key)
                    report_mismatch($sformatf("key_index %0d, expected %0d",
                                              key_index, want.key));
                if (event_kind !== want.kind)
                    report_mismatch($sformatf("event_kind %0d for key %0d, expected %0d",
                                              event_kind, want.key, want.kind));
                if (last_event !== want.last)
                    report_mismatch($sformatf("last_event %0d for key %0d, expected %0d",
                                              last_event, want.key, want.last));
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // watchdog on cycles without any transaction
    initial
    begin
        do
            @(posedge clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        logic [15:0] cur_keys;
        logic [31:0] cur_tick;
        int db_ticks;
        int hold_ticks;
        int scan_count;
        int pick;
        int i;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        keys_down    = '0;
        now_tick     = '0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = kdb_pkg::REG_DEBOUNCE;
        cfg_data     = '0;
        mismatches   = 0;
        quiet_cycles = 0;
        send_gap_pct = 6;
        stall_pct    = 81;
        cand_keys    = '0;
        cand_tick    = '0;
        scan_seen    = 1'b0;
        settled_keys = '0;
        hold_flagged = '0;
        cfg_debounce = kdb_pkg::DEBOUNCE_RST;
        cfg_hold     = kdb_pkg::HOLD_RST;
        cfg_period   = kdb_pkg::PERIOD_RST;
        for (i = 0; i < 16; i++)
            down_tick[i] = '0;
        cur_keys     = '0;
        cur_tick     = 32'h00001000;
        scan_count   = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed scans
        foreach (scan_table[r])
            send_scan(scan_table[r].keys, scan_table[r].tick, scan_table[r].typed,
                      scan_table[r].hold_mask, scan_table[r].press_mask);
        settle();

        // random scans, one register setting per phase
        foreach (phase_table[p])
        begin
            write_reg(kdb_pkg::REG_DEBOUNCE, phase_table[p].debounce);
            write_reg(kdb_pkg::REG_HOLD, phase_table[p].hold);
            write_reg(kdb_pkg::REG_PERIOD, phase_table[p].period);
            if (phase_table[p].spare_write)
                write_reg(REG_SPARE, 16'h0005);
            cfg_valid <= 1'b0;
            db_ticks   = (cfg_period == 0) ? 1 : int'(cfg_debounce) / int'(cfg_period);
            hold_ticks = (cfg_period == 0) ? 1 : int'(cfg_hold) / int'(cfg_period);
            repeat (phase_table[p].scans)
            begin
                if (scan_count < 107)
                begin
                    send_gap_pct = 6;
                    stall_pct    = 81;
                end
                else if (scan_count < 214)
                begin
                    send_gap_pct = 81;
                    stall_pct    = 6;
                end
                else
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                // mostly a steady bitmap so scans settle, with toggles and noise
                pick = $urandom_range(0, 99);
                if (pick >= 95)
                    cur_keys = 16'($urandom);
                else if (pick >= 85)
                    cur_keys ^= 16'($urandom) & 16'($urandom);
                else if (pick >= 65)
                    cur_keys ^= 16'(1) << $urandom_range(0, 15);
                // tick steps around the debounce and hold times, rarely a jump
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    cur_tick += 32'($urandom_range(0, db_ticks + 1));
                else if (pick < 95)
                    cur_tick += 32'($urandom_range(0, hold_ticks / 2 + 1));
                else
                    cur_tick = $urandom;
                send_scan(cur_keys, cur_tick, 1'b0, '0, '0);
                scan_count++;
            end
            settle();
        end

        if (mismatches == 0 && pending_events.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
